FILE: hw/rtl/tppc_pkg.sv
// Shared types and constants for the trie prefix pair counter.
// No dependencies; imported by the top level and the update step module.
`default_nettype none

package tppc_pkg;

    localparam int LETTER_W    = 5;
    localparam int TOTAL_W     = 48;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 48;
    localparam int M_TUSER_W   = 1;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_BUSY  = 3'b100
    } state_t;

    // Decisions of one update step, handed from the step logic to the top level.
    typedef struct packed {
        logic mem_we;        // write the child entry back
        logic take_node;     // a fresh node was allocated
        logic move_cursor;   // the cursor follows the written child
        logic set_overflow;  // pool was full
        logic set_skip;      // ignore the rest of this string
    } step_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/trie_prefix_pair_counter.sv
// Top level of the trie prefix pair counter: child table memory, sequencer, output register.
// Depends on tppc_pkg and tppc_step.
`default_nettype none

// Channel   Dir  Contents
// s_axis    in   tdata[4:0] letter, tlast end_of_string
// m_axis    out  tdata[47:0] pair_prefix_total, tuser[0] pool_overflow
//
// Each input beat has an accept cycle, in which the child entry of the current node is
// read from the single-port child table, and an update step after it, held until the output
// register is free, in which the entry is updated and written back and the result is loaded.
// After reset a clearing pass zeroes all MAX_NODES * ALPHABET_SIZE entries of the child
// table (26624 at the defaults), one entry a cycle; s_tready is low meanwhile.
// A result that waits on m_tready holds the update cycle; a new beat can be
// accepted while an earlier result still sits in the output register.

module trie_prefix_pair_counter #(
    parameter int MAX_NODES     = 1024,
    parameter int ALPHABET_SIZE = 26,
    parameter int COUNT_WIDTH   = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tppc_pkg::S_TDATA_W-1:0]    s_tdata,   // [4:0] letter, [7:5] zero
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [tppc_pkg::M_TDATA_W-1:0]    m_tdata,   // [47:0] pair_prefix_total
    output logic      [tppc_pkg::M_TUSER_W-1:0]    m_tuser    // [0] pool_overflow
);
    import tppc_pkg::*;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int USED_W  = $clog2(MAX_NODES + 1);
    localparam int DEPTH   = MAX_NODES * ALPHABET_SIZE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ENTRY_W = NODE_W + COUNT_WIDTH;
    localparam int CMP_W   = 9;

    // Each child entry carries the child's index together with the child's pass
    // count, since every node has exactly one parent slot.
    logic [ENTRY_W-1:0] child_mem [DEPTH];

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clear_addr_reg, clear_addr_next;
    logic [ENTRY_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]  slot_reg;
    logic               eos_reg;
    logic               oor_reg;
    logic [NODE_W-1:0]  cursor_reg, cursor_next;
    logic [USED_W-1:0]  nodes_used_reg, nodes_used_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               skip_reg, skip_next;
    logic               overflow_reg, overflow_next;
    logic               m_tvalid_reg, m_tvalid_next;

    logic [LETTER_W-1:0] letter;
    logic                letter_ok;
    logic [ADDR_W-1:0]   rd_addr;
    logic                s_accept;
    logic                finish;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;

    step_ctrl_t          ctrl;
    logic [NODE_W-1:0]   wr_child;
    logic [COUNT_WIDTH-1:0] wr_count;
    logic [TOTAL_W-1:0]  total_upd;

    assign letter    = s_tdata[LETTER_W-1:0];
    assign letter_ok = CMP_W'(letter) < CMP_W'(ALPHABET_SIZE);
    // Out-of-range letters are ignored, so their read address is irrelevant.
    assign rd_addr   = letter_ok
                     ? ADDR_W'(ADDR_W'(cursor_reg) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(letter))
                     : '0;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign finish    = (state_reg == ST_BUSY) && (!m_tvalid_reg || m_tready);

    tppc_step #(
        .MAX_NODES   (MAX_NODES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .ignore      (skip_reg || oor_reg),
        .nodes_used  (nodes_used_reg),
        .entry_child (rdata_reg[NODE_W-1:0]),
        .entry_count (rdata_reg[ENTRY_W-1:NODE_W]),
        .total_in    (total_reg),
        .ctrl        (ctrl),
        .wr_child    (wr_child),
        .wr_count    (wr_count),
        .total_out   (total_upd)
    );

    // The clearing pass and the update share the one write port.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clear_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = finish && ctrl.mem_we;
            mem_waddr = slot_reg;
            mem_wdata = {wr_count, wr_child};
        end
    end

    // A write lands before the next beat can be accepted, so reads never see stale data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            child_mem[mem_waddr] <= mem_wdata;
        end
        if (s_accept) begin
            rdata_reg <= child_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            slot_reg <= rd_addr;
            eos_reg  <= s_tlast;
            oor_reg  <= !letter_ok;
        end
        if (finish) begin
            m_tdata    <= total_upd;
            m_tuser[0] <= overflow_reg || ctrl.set_overflow;
        end
    end

    always_comb begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clear_addr_next = clear_addr_reg + ADDR_W'(1);
                if (clear_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cursor_next     = cursor_reg;
        nodes_used_next = nodes_used_reg;
        total_next      = total_reg;
        skip_next       = skip_reg;
        overflow_next   = overflow_reg;
        if (finish) begin
            total_next    = total_upd;
            overflow_next = overflow_reg || ctrl.set_overflow;
            if (ctrl.take_node) begin
                nodes_used_next = nodes_used_reg + USED_W'(1);
            end
            if (eos_reg) begin
                // The last letter of a string sends the cursor home.
                cursor_next = '0;
                skip_next   = 1'b0;
            end else begin
                skip_next = skip_reg || ctrl.set_skip;
                if (ctrl.move_cursor) begin
                    cursor_next = wr_child;
                end
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            cursor_reg     <= '0;
            nodes_used_reg <= USED_W'(1);
            total_reg      <= '0;
            skip_reg       <= 1'b0;
            overflow_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            cursor_reg     <= cursor_next;
            nodes_used_reg <= nodes_used_next;
            total_reg      <= total_next;
            skip_reg       <= skip_next;
            overflow_reg   <= overflow_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tppc_step.sv
// Combinational update of one letter: decides allocation, the new child entry and the total.
// Depends on tppc_pkg.
`default_nettype none

module tppc_step #(
    parameter int MAX_NODES   = 1024,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                              ignore,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]    nodes_used,
    input  wire logic [$clog2(MAX_NODES)-1:0]      entry_child,
    input  wire logic [COUNT_WIDTH-1:0]            entry_count,
    input  wire logic [tppc_pkg::TOTAL_W-1:0]      total_in,
    output tppc_pkg::step_ctrl_t                   ctrl,
    output logic      [$clog2(MAX_NODES)-1:0]      wr_child,
    output logic      [COUNT_WIDTH-1:0]            wr_count,
    output logic      [tppc_pkg::TOTAL_W-1:0]      total_out
);
    import tppc_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int USED_W = $clog2(MAX_NODES + 1);

    logic [TOTAL_W:0] sum;

    assign sum = {1'b0, total_in} + (TOTAL_W+1)'(entry_count);

    always_comb begin
        ctrl      = '0;
        wr_child  = entry_child;
        wr_count  = entry_count;
        total_out = total_in;
        if (!ignore) begin
            if (entry_child == '0) begin
                if (nodes_used == USED_W'(MAX_NODES)) begin
                    ctrl.set_overflow = 1'b1;
                    ctrl.set_skip     = 1'b1;
                end else begin
                    // A new node starts with a pass count of zero, which adds nothing.
                    ctrl.take_node   = 1'b1;
                    ctrl.mem_we      = 1'b1;
                    ctrl.move_cursor = 1'b1;
                    wr_child         = nodes_used[NODE_W-1:0];
                    wr_count         = COUNT_WIDTH'(1);
                end
            end else begin
                ctrl.mem_we      = 1'b1;
                ctrl.move_cursor = 1'b1;
                total_out        = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                if (entry_count != '1) begin
                    wr_count = entry_count + COUNT_WIDTH'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tppc_checker.sv
// Port-level checker for the trie prefix pair counter, bound to the top level.
// Depends on tppc_pkg and trie_prefix_pair_counter.
`default_nettype none

module tppc_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [tppc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic [tppc_pkg::M_TUSER_W-1:0]    m_tuser
);
    import tppc_pkg::*;

    logic [1:0]           pending_reg;
    logic                 ovf_seen_reg;
    logic [M_TDATA_W-1:0] last_total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg    <= '0;
            ovf_seen_reg   <= 1'b0;
            last_total_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
            if (m_tvalid && m_tready) begin
                ovf_seen_reg   <= ovf_seen_reg || m_tuser[0];
                last_total_reg <= m_tdata;
            end
        end
    end

    // A held result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Every result belongs to an accepted beat.
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("result without an accepted beat");

    // Overflow never clears once reported.
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ovf_seen_reg |-> m_tuser[0])
        else $error("overflow flag dropped");

    // The running total never decreases.
    a_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata >= last_total_reg)
        else $error("total decreased");

endmodule

bind trie_prefix_pair_counter tppc_checker u_tppc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/trie_prefix_pair_counter_tb.sv
// Self-checking testbench for the trie prefix pair counter: streams strings, predicts every
// running total and overflow flag, and compares each result beat as it leaves the block.
// Depends on tppc_pkg and the trie_prefix_pair_counter RTL.
`default_nettype none

module trie_prefix_pair_counter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tppc_pkg::*;

    localparam int MAX_NODES     = 1024;
    localparam int ALPHABET_SIZE = 26;
    localparam int COUNT_WIDTH   = 16;
    localparam int NODE_W        = $clog2(MAX_NODES);

    // One expected result beat: the running total and the sticky overflow flag.
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               overflow;
    } tally_t;

    // Scoreboard: keeps its own trie, works out the result of every accepted letter
    // and checks the result beats against those predictions in order.
    class trie_tally;
        logic [NODE_W-1:0]      child_of [MAX_NODES*ALPHABET_SIZE];
        logic [COUNT_WIDTH-1:0] passes [MAX_NODES];
        int unsigned            nodes_used;
        logic [NODE_W-1:0]      cursor;
        logic [TOTAL_W-1:0]     total;
        bit                     skip_rest;
        bit                     overflow;
        tally_t                 totals_due[$];
        int                     failures;

        function new();
            foreach (child_of[i]) child_of[i] = '0;
            foreach (passes[i]) passes[i] = '0;
            nodes_used = 1;
            cursor     = '0;
            total      = '0;
            skip_rest  = 1'b0;
            overflow   = 1'b0;
            failures   = 0;
        endfunction

        // Walks one letter into the trie and queues the result it must produce.
        function void note_beat(logic [LETTER_W-1:0] letter, logic last);
            int unsigned            slot;
            logic [NODE_W-1:0]      next;
            logic [COUNT_WIDTH-1:0] old;
            logic [TOTAL_W:0]       sum;
            tally_t                 due;
            if (!skip_rest && letter < ALPHABET_SIZE) begin
                slot = cursor * ALPHABET_SIZE + letter;
                next = child_of[slot];
                if (next == '0 && nodes_used >= MAX_NODES) begin
                    // No room for the child: the rest of this string is dropped.
                    skip_rest = 1'b1;
                    overflow  = 1'b1;
                end else begin
                    if (next == '0) begin
                        next = nodes_used[NODE_W-1:0];
                        nodes_used++;
                        passes[next]   = '0;
                        child_of[slot] = next;
                    end
                    cursor = next;
                    old    = passes[next];
                    sum    = {1'b0, total} + old;
                    total  = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                    if (old != '1) passes[next] = old + 1'b1;
                end
            end
            if (last) begin
                cursor    = '0;
                skip_rest = 1'b0;
            end
            due.total    = total;
            due.overflow = overflow;
            totals_due.insert(totals_due.size(), due);
        endfunction

        function void check_beat(logic [TOTAL_W-1:0] got_total, logic got_overflow);
            tally_t want;
            if (totals_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: unexpected result beat total=%0d overflow=%0b",
                             got_total, got_overflow);
            end else begin
                want = totals_due.pop_front();
                if (want.total !== got_total || want.overflow !== got_overflow) begin
                    failures++;
                    if (failures <= 10)
                        $display("ERROR: total exp %0d got %0d, overflow exp %0b got %0b",
                                 want.total, got_total, want.overflow, got_overflow);
                end
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Percent chance per cycle that the sender holds back or the receiver stalls.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    // Letters within the alphabet sent so far in the current random stretch.
    int letters_sent  = 0;

    trie_tally board;

    trie_prefix_pair_counter #(
        .MAX_NODES     (MAX_NODES),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [4:0] letter, [7:5] zero
        .s_tlast  (s_tlast),   // end_of_string
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [47:0] pair_prefix_total
        .m_tuser  (m_tuser)    // [0] pool_overflow
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // The receiver decides at every falling edge whether it takes a beat next cycle.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Both channels are observed at the rising edge, where a handshake completes.
    // An input beat can never leave the block in the same cycle, so the order of the
    // two calls does not matter.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_beat(s_tdata[LETTER_W-1:0], s_tlast);
            if (m_tvalid && m_tready)
                board.check_beat(m_tdata[TOTAL_W-1:0], m_tuser[0]);
        end
    end

    // Offers one beat. Called at a falling edge and returns at the falling edge after
    // the beat was taken, so s_tvalid stays high between back-to-back beats.
    task automatic send_letter(input logic [LETTER_W-1:0] letter, input logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-LETTER_W){1'b0}}, letter};
        s_tlast  <= last;
        if (letter < ALPHABET_SIZE) letters_sent++;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Sends one string. A narrow span of letters makes strings share prefixes, so the
    // totals climb; the full span mostly allocates fresh nodes. With noise on, a few
    // out-of-range codes are mixed in.
    task automatic send_word(input int len, input int span, input bit noise);
        logic [LETTER_W-1:0] letter;
        for (int i = 0; i < len; i++) begin
            letter = LETTER_W'($urandom_range(span - 1));
            if (noise && $urandom_range(9) == 0)
                letter = LETTER_W'($urandom_range(31, ALPHABET_SIZE));
            send_letter(letter, i == len - 1);
        end
    endtask

    // Mostly well-formed strings with random content, with a share of loose beats
    // that carry any code and a random end flag.
    task automatic random_words(input int beats);
        letters_sent = 0;
        while (letters_sent < beats) begin
            if ($urandom_range(9) == 0)
                send_letter(LETTER_W'($urandom_range(31)), 1'($urandom_range(1)));
            else
                send_word($urandom_range(1, 8), $urandom_range(1) ? 3 : ALPHABET_SIZE,
                          $urandom_range(3) == 0);
        end
    endtask

    initial begin
        board = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, with no idling. Repeated strings give the first nonzero
        // totals, then the extreme letter codes and each end bit pattern.
        send_letter(0, 1);
        send_letter(0, 1);
        send_letter(0, 0);
        send_letter(1, 1);
        send_letter(25, 1);
        send_letter(16, 0);
        send_letter(15, 1);
        // Out-of-range codes in the middle of a string are ignored, and the string
        // goes on from where it was.
        send_letter(26, 0);
        send_letter(0, 0);
        send_letter(31, 0);
        send_letter(2, 1);
        // An out-of-range code that ends a string still sends the cursor home.
        send_letter(0, 0);
        send_letter(31, 1);
        send_letter(30, 1);
        send_letter(0, 0);
        send_letter(1, 0);
        send_letter(2, 0);
        send_letter(3, 1);
        send_letter(0, 0);
        send_letter(1, 0);
        send_letter(2, 1);
        send_letter(25, 0);
        send_letter(25, 0);
        send_letter(25, 1);

        // Random strings under the four idling patterns.
        send_idle_pct = 0;
        stall_pct     = 0;
        random_words(200);
        send_idle_pct = 70;
        stall_pct     = 0;
        random_words(200);
        send_idle_pct = 0;
        stall_pct     = 70;
        random_words(200);
        send_idle_pct = 26;
        stall_pct     = 26;
        random_words(200);

        s_tvalid <= 1'b0;
        while (board.totals_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.failures == 0 && board.totals_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Far beyond the slowest correct run: the clearing pass and all strings at the
    // worst idling together take well under a millisecond.
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/tppc_pkg.sv
hw/rtl/tppc_step.sv
hw/rtl/trie_prefix_pair_counter.sv
hw/rtl/tppc_checker.sv
tb/trie_prefix_pair_counter_tb.sv
